// ===== sv/cqs_pkg.sv =====
// ---------------------------------------------------------------------------
// cqs_pkg: shared types and codes for the circular queue core
// Command and status codes, the stored entry layout, the response record
// and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

   // Command codes carried by a request.
   localparam logic [2:0] CMD_ENQUEUE = 3'd0;
   localparam logic [2:0] CMD_DEQUEUE = 3'd1;
   localparam logic [2:0] CMD_PEEK    = 3'd2;
   localparam logic [2:0] CMD_SEARCH  = 3'd3;
   localparam logic [2:0] CMD_CANCEL  = 3'd4;
   localparam logic [2:0] CMD_COUNT   = 3'd5;

   // Status codes carried by a response.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Search reports at most this many matches.
   localparam int MAX_RESULTS = 16;

   // Service id counter value after reset; the first id handed out is one above.
   localparam logic [15:0] FIRST_ID_BASE = 16'd700;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] service;
      logic [15:0] train;
      logic [1:0]  kind;
   } entry_type;

   // One response as it leaves the core.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] service_number;
      logic [15:0] train_out;
      logic [1:0]  kind_out;
      logic [4:0]  position;
      logic [4:0]  occupancy;
      logic [4:0]  routine_total;
      logic [4:0]  repair_total;
      logic [4:0]  emergency_total;
      logic [4:0]  other_total;
      logic        last;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENQUEUE,
      ST_HEAD,
      ST_STATUS,
      ST_SEARCH,
      ST_SEARCH_END,
      ST_FIND,
      ST_SHIFT,
      ST_CANCEL_END,
      ST_COUNT,
      ST_COUNT_END
   } state_type;

endpackage

`default_nettype wire

// ===== sv/circular_queue_with_cancel_and_search_core.sv =====
// Enqueue, dequeue, peek and refusals go from idle to one result state (ENQUEUE, HEAD or
// STATUS), which loads the response register once it is free, then back to idle. Search,
// cancel and count walk the entries one per cycle through the shared slot adders and the
// train and key compares; a search holds an entry that matches while an older match waits.
// Synchronous active-high reset empties the queue and sets the id counter to 700;
// the entry store itself is not cleared.
// ---------------------------------------------------------------------------
// circular_queue_with_cancel_and_search_core: keyed circular queue
// Bounded FIFO of service records with search by train id, cancel by
// service id and per-type counting.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_cancel_and_search_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_train_number,
   input  logic [1:0]  req_kind_code,
   input  logic [15:0] req_service_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_service_number,
   output logic [15:0] rsp_train_out,
   output logic [1:0]  rsp_kind_out,
   output logic [4:0]  rsp_position,
   output logic [4:0]  rsp_occupancy,
   output logic [4:0]  rsp_routine_total,
   output logic [4:0]  rsp_repair_total,
   output logic [4:0]  rsp_emergency_total,
   output logic [4:0]  rsp_other_total,
   output logic        rsp_last
);
   import cqs_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          wr_en;
   entry_type     wr_data;
   entry_type     rd_data;
   logic          push;
   rsp_type       push_data;
   logic          out_free;
   rsp_type       rsp_data;

   // Sequencer.
   cqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_train_number (req_train_number),
      .req_kind_code    (req_kind_code),
      .req_service_key  (req_service_key),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .push             (push),
      .push_data        (push_data),
      .out_free         (out_free)
   );

   // Entry storage.
   cqs_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response register.
   cqs_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Response fields to ports.
   assign rsp_status          = rsp_data.status;
   assign rsp_service_number  = rsp_data.service_number;
   assign rsp_train_out       = rsp_data.train_out;
   assign rsp_kind_out        = rsp_data.kind_out;
   assign rsp_position        = rsp_data.position;
   assign rsp_occupancy       = rsp_data.occupancy;
   assign rsp_routine_total   = rsp_data.routine_total;
   assign rsp_repair_total    = rsp_data.repair_total;
   assign rsp_emergency_total = rsp_data.emergency_total;
   assign rsp_other_total     = rsp_data.other_total;
   assign rsp_last            = rsp_data.last;

endmodule

`default_nettype wire

// ===== sv/cqs_store.sv =====
// ---------------------------------------------------------------------------
// cqs_store: entry storage of the circular queue
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cqs_store #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  cqs_pkg::entry_type         wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output cqs_pkg::entry_type         rd_data
);
   import cqs_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, read data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/cqs_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// cqs_rsp_reg: response output register
// Holds one finished response until the consumer takes it, so the
// sequencer can go on with the next request meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module cqs_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cqs_pkg::rsp_type push_data,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cqs_pkg::rsp_type rsp_data
);
   import cqs_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // The slot is free when empty or being drained in this cycle.
   assign free         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, loaded only on a push.
   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/cqs_ctrl.sv =====
// ---------------------------------------------------------------------------
// cqs_ctrl: command sequencer and entry walker
// Keeps the queue pointers and walks the stored entries one per cycle (search stalls
// on a waiting match) through shared slot adders and compares for search, cancel, count.
// ---------------------------------------------------------------------------
`default_nettype none

module cqs_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_command,
   input  logic [15:0]              req_train_number,
   input  logic [1:0]               req_kind_code,
   input  logic [15:0]              req_service_key,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  cqs_pkg::entry_type       rd_data,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output cqs_pkg::entry_type       wr_data,
   output logic                     push,
   output cqs_pkg::rsp_type         push_data,
   input  logic                     out_free
);
   import cqs_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W    = (IW + 1)'(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [4:0]    CAP_MATCH  = 5'(MAX_RESULTS - 1);

   // Slot arithmetic modulo DEPTH.
   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                              input logic [IW-1:0] b);
      logic [IW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] a);
      return (a == '0) ? LAST_SLOT : a - 1'b1;
   endfunction

   state_type     state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   id_ff, id_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [15:0]   train_ff, train_in;
   logic [1:0]    kind_ff, kind_in;
   logic [15:0]   key_ff, key_in;
   logic [1:0]    status_ff, status_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [4:0]    nmatch_ff, nmatch_in;
   logic          hold_valid_ff, hold_valid_in;
   entry_type     hold_entry_ff, hold_entry_in;
   logic [4:0]    hold_pos_ff, hold_pos_in;
   logic [IW-1:0] dst_ff, dst_in;
   logic [CW-1:0] tally_ff [4];
   logic [CW-1:0] tally_in [4];

   logic [IW-1:0] cur_slot;
   logic [IW-1:0] next_slot;
   logic [IW-1:0] idx_nx;
   logic [CW-1:0] idx_p1;
   logic          at_end;
   logic          empty;
   logic          full;
   logic          train_match;
   logic          key_match;
   logic          cap;
   logic          search_take;
   logic [15:0]   id_next;

   // Walk unit: slot of the entry on the read port and of the one after it.
   assign idx_nx      = idx_ff + 1'b1;
   assign idx_p1      = CW'(idx_ff) + CW'(1);
   assign cur_slot    = wrap_add(head_ff, idx_ff);
   assign next_slot   = wrap_add(head_ff, idx_nx);
   assign at_end      = (idx_p1 == count_ff);
   assign empty       = (count_ff == '0);
   assign full        = (count_ff >= FULL_COUNT);
   assign train_match = (rd_data.train == train_ff);
   assign key_match   = (rd_data.service == key_ff);
   assign cap         = train_match && (nmatch_ff == CAP_MATCH);
   assign id_next     = id_ff + 16'd1;

   // A search entry is consumed unless it matches while an older held match cannot yet go out.
   assign search_take = !(train_match && hold_valid_ff) || out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command) inside
                  CMD_ENQUEUE:           state_in = full  ? ST_STATUS : ST_ENQUEUE;
                  CMD_DEQUEUE, CMD_PEEK: state_in = empty ? ST_STATUS : ST_HEAD;
                  CMD_SEARCH:            state_in = empty ? ST_STATUS : ST_SEARCH;
                  CMD_CANCEL:            state_in = empty ? ST_STATUS : ST_FIND;
                  CMD_COUNT:             state_in = empty ? ST_STATUS : ST_COUNT;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENQUEUE, ST_HEAD, ST_STATUS, ST_SEARCH_END, ST_CANCEL_END, ST_COUNT_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (search_take && (at_end || cap)) begin
               state_in = ST_SEARCH_END;
            end
         end
         ST_FIND: begin
            if (key_match) begin
               state_in = at_end ? ST_CANCEL_END : ST_SHIFT;
            end else if (at_end) begin
               state_in = ST_STATUS;
            end
         end
         ST_SHIFT: begin
            if (at_end) begin
               state_in = ST_CANCEL_END;
            end
         end
         ST_COUNT: begin
            if (at_end) begin
               state_in = ST_COUNT_END;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory port and response for each state.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      cmd_in        = cmd_ff;
      train_in      = train_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      nmatch_in     = nmatch_ff;
      hold_valid_in = hold_valid_ff;
      hold_entry_in = hold_entry_ff;
      hold_pos_in   = hold_pos_ff;
      dst_in        = dst_ff;
      tally_in      = tally_ff;
      req_ready     = 1'b0;
      rd_addr       = cur_slot;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = rd_data;
      push          = 1'b0;
      push_data           = '0;
      push_data.occupancy = 5'(count_ff);
      push_data.last      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            // Present the head entry so a walk can start on the next cycle.
            req_ready = 1'b1;
            rd_addr   = head_ff;
            if (req_valid) begin
               cmd_in        = req_command;
               train_in      = req_train_number;
               kind_in       = req_kind_code;
               key_in        = req_service_key;
               idx_in        = '0;
               nmatch_in     = '0;
               hold_valid_in = 1'b0;
               tally_in      = '{default: '0};
               status_in     = (req_command == CMD_ENQUEUE) ? STATUS_FULL : STATUS_EMPTY;
            end
         end

         ST_ENQUEUE: begin
            if (out_free) begin
               wr_en        = 1'b1;
               wr_addr      = wrap_inc(tail_ff);
               wr_data      = '{service: id_next, train: train_ff, kind: kind_ff};
               tail_in      = wrap_inc(tail_ff);
               id_in        = id_next;
               count_in     = count_ff + CW'(1);
               push         = 1'b1;
               push_data.service_number = id_next;
               push_data.train_out      = train_ff;
               push_data.kind_out       = kind_ff;
               push_data.occupancy      = 5'(count_ff + CW'(1));
            end
         end

         ST_HEAD: begin
            if (out_free) begin
               push = 1'b1;
               push_data.service_number = rd_data.service;
               push_data.train_out      = rd_data.train;
               push_data.kind_out       = rd_data.kind;
               if (cmd_ff == CMD_DEQUEUE) begin
                  head_in  = wrap_inc(head_ff);
                  count_in = count_ff - CW'(1);
                  push_data.occupancy = 5'(count_ff - CW'(1));
               end
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               push             = 1'b1;
               push_data.status = status_ff;
            end
         end

         ST_SEARCH: begin
            // The latest match is held back until it is known whether it is the last.
            if (train_match && search_take) begin
               if (hold_valid_ff) begin
                  push = 1'b1;
                  push_data.service_number = hold_entry_ff.service;
                  push_data.train_out      = hold_entry_ff.train;
                  push_data.kind_out       = hold_entry_ff.kind;
                  push_data.position       = hold_pos_ff;
                  push_data.last           = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_entry_in = rd_data;
               hold_pos_in   = 5'(idx_p1);
               nmatch_in     = nmatch_ff + 5'd1;
            end
            if (search_take && !at_end && !cap) begin
               rd_addr = next_slot;
               idx_in  = idx_nx;
            end
         end

         ST_SEARCH_END: begin
            if (out_free) begin
               push = 1'b1;
               if (hold_valid_ff) begin
                  push_data.service_number = hold_entry_ff.service;
                  push_data.train_out      = hold_entry_ff.train;
                  push_data.kind_out       = hold_entry_ff.kind;
                  push_data.position       = hold_pos_ff;
               end else begin
                  push_data.status = STATUS_NOT_FOUND;
               end
            end
         end

         ST_FIND: begin
            dst_in = cur_slot;
            if (key_match) begin
               hold_entry_in = rd_data;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
            if (!at_end) begin
               rd_addr = next_slot;
               idx_in  = idx_nx;
            end
         end

         ST_SHIFT: begin
            // Move each later entry one slot toward the head.
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = rd_data;
            dst_in  = cur_slot;
            if (!at_end) begin
               rd_addr = next_slot;
               idx_in  = idx_nx;
            end
         end

         ST_CANCEL_END: begin
            if (out_free) begin
               tail_in  = wrap_dec(tail_ff);
               count_in = count_ff - CW'(1);
               push     = 1'b1;
               push_data.service_number = hold_entry_ff.service;
               push_data.train_out      = hold_entry_ff.train;
               push_data.kind_out       = hold_entry_ff.kind;
               push_data.occupancy      = 5'(count_ff - CW'(1));
            end
         end

         ST_COUNT: begin
            tally_in[rd_data.kind] = tally_ff[rd_data.kind] + CW'(1);
            if (!at_end) begin
               rd_addr = next_slot;
               idx_in  = idx_nx;
            end
         end

         ST_COUNT_END: begin
            if (out_free) begin
               push = 1'b1;
               push_data.routine_total   = 5'(tally_ff[0]);
               push_data.repair_total    = 5'(tally_ff[1]);
               push_data.emergency_total = 5'(tally_ff[2]);
               push_data.other_total     = 5'(tally_ff[3]);
            end
         end

         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= LAST_SLOT;
         count_ff      <= '0;
         id_ff         <= FIRST_ID_BASE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         id_ff         <= id_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      train_ff      <= train_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      nmatch_ff     <= nmatch_in;
      hold_entry_ff <= hold_entry_in;
      hold_pos_ff   <= hold_pos_in;
      dst_ff        <= dst_in;
      tally_ff      <= tally_in;
   end

endmodule

`default_nettype wire

// ===== sv/cqs_checker.sv =====
// ---------------------------------------------------------------------------
// cqs_checker: port-level checks for the circular queue core
// Watches the request and response channels and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cqs_checker #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_service_number,
   input logic [15:0] rsp_train_out,
   input logic [4:0]  rsp_position,
   input logic [4:0]  rsp_occupancy,
   input logic        rsp_last
);
   import cqs_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_service_number,
                                                        rsp_train_out, rsp_position,
                                                        rsp_last}))
      else $error("response changed while stalled");

   // Any refusal or miss is the only response of its request.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last)
      else $error("non-ok response not marked last");

   // A full refusal reports a full queue.
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_occupancy == 5'(DEPTH))
      else $error("full status with wrong occupancy");

   // An empty refusal reports an empty queue and no position.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_occupancy == 5'd0 && rsp_position == 5'd0)
      else $error("empty status with nonzero occupancy or position");

   // A valid command keeps the core busy on the cycle after it is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command <= CMD_COUNT |=> !req_ready)
      else $error("request ready right after a command was taken");

endmodule

bind circular_queue_with_cancel_and_search_core cqs_checker #(.DEPTH(DEPTH)) u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_service_number (rsp_service_number),
   .rsp_train_out      (rsp_train_out),
   .rsp_position       (rsp_position),
   .rsp_occupancy      (rsp_occupancy),
   .rsp_last           (rsp_last)
);

`default_nettype wire
